### rtl/core/wfgdd_pkg.sv
// wfgdd_pkg: shared constants, codes and control types of the wait-for graph deadlock detector
// used by wfgdd_ctrl, wfgdd_datapath and wait_for_graph_deadlock_detect; depends on nothing
package wfgdd_pkg;

    localparam int PROC_NUM = 16;              // process rows held
    localparam int RES_NUM  = 16;              // resource bits per row
    localparam int PROC_W   = $clog2(PROC_NUM);
    localparam int CNT_W    = PROC_W + 1;      // counts 0 .. PROC_NUM

    localparam logic [CNT_W-1:0] PROC_LIMIT = CNT_W'(PROC_NUM);
    localparam logic [CNT_W-1:0] RES_LIMIT  = CNT_W'(RES_NUM);

    // input item layout
    localparam int S_TDATA_W = 40;
    localparam int IDX_LSB   = 0;
    localparam int HELD_LSB  = IDX_LSB + PROC_W;
    localparam int REQ_LSB   = HELD_LSB + RES_NUM;

    // result item layout
    localparam int M_TDATA_W = 8;

    // command codes
    localparam logic CMD_ROW    = 1'b0;
    localparam logic CMD_DETECT = 1'b1;

    // configuration register indexes
    localparam logic CFG_PROC_COUNT = 1'b0;
    localparam logic CFG_RES_COUNT  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_STEP,
        ST_EMIT,
        ST_CLOSE,
        ST_NONE
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic row_wr;
        logic search_init;
        logic start_skip;
        logic start_push;
        logic pop;
        logic advance;
        logic push_child;
        logic mark_found;
        logic emit_node;
        logic emit_close;
        logic emit_none;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic start_done;
        logic start_visited;
        logic sp_zero;
        logic v_done;
        logic has_edge;
        logic v_visited;
        logic v_onstack;
        logic emit_end;
        logic out_free;
    } dp_status_t;

endpackage

### rtl/core/wait_for_graph_deadlock_detect.sv
// wait_for_graph_deadlock_detect: top level of the wait-for graph deadlock detector
// depends on wfgdd_pkg, wfgdd_ctrl and wfgdd_datapath
//
// usage:
//   s_ channel: one item per command. tuser = cmd (row write or detect), tdata carries
//   the process index and its held and request masks (ignored on detect).
//   m_ channel: results of a detect. tuser = deadlock flag, tdata = process id,
//   tlast marks the final item. a deadlock gives the cycle from its start node to its
//   end node and then the start node again; an acyclic graph gives one item.
//   cfg_ channel: index 0 writes proc_count, index 1 res_count; always ready. the user
//   must write it only while no detect is in flight; the block does not enforce this.
// timing:
//   a row write gives no item. a detect runs the search one step a cycle: a step per start
//   node, per (node, neighbor) probe, per pop and per return to the start scan, then emits
//   the result items, holding while the output register is full.
//   the rate is set by the single adjacency probe the search loop makes per cycle.
//   s_tready stays low from a detect until its last item sits in the output register.
// reset: configuration returns to 16 processes and 16 resources, all rows clear.
// stall: results wait in the output register while m_tready is low; the emission halts
//   on the next item until the register frees up.
module wait_for_graph_deadlock_detect (
    input  logic                              aclk,
    input  logic                              aresetn,
    // slave side
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [wfgdd_pkg::S_TDATA_W-1:0]   s_tdata,   // proc_index, held_mask, request_mask, zero pad
    input  logic [0:0]                        s_tuser,   // cmd
    // master side
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [wfgdd_pkg::M_TDATA_W-1:0]   m_tdata,   // proc_id, zero pad
    output logic [0:0]                        m_tuser,   // deadlock
    output logic                              m_tlast,
    // configuration write channel
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic                              cfg_index,
    input  logic [wfgdd_pkg::CNT_W-1:0]       cfg_data
);

    wfgdd_pkg::dp_cmd_t              dp_cmd;
    wfgdd_pkg::dp_status_t           dp_status;
    logic                            out_deadlock;
    logic [wfgdd_pkg::PROC_W-1:0]    out_id;

    // configuration never stalls
    assign cfg_ready = 1'b1;

    wfgdd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_cmd   (s_tuser[0]),
        .cmd      (dp_cmd),
        .status   (dp_status)
    );

    wfgdd_datapath u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (dp_cmd),
        .status       (dp_status),
        .row_idx      (s_tdata[wfgdd_pkg::IDX_LSB +: wfgdd_pkg::PROC_W]),
        .row_held     (s_tdata[wfgdd_pkg::HELD_LSB +: wfgdd_pkg::RES_NUM]),
        .row_req      (s_tdata[wfgdd_pkg::REQ_LSB +: wfgdd_pkg::RES_NUM]),
        .cfg_wr       (cfg_valid && cfg_ready),
        .cfg_idx      (cfg_index),
        .cfg_val      (cfg_data),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_deadlock (out_deadlock),
        .out_id       (out_id),
        .out_last     (m_tlast)
    );

    // result packing: id in the low bits, zero fill above
    assign m_tdata = {{(wfgdd_pkg::M_TDATA_W - wfgdd_pkg::PROC_W){1'b0}}, out_id};
    assign m_tuser = out_deadlock;

endmodule

### rtl/core/wfgdd_datapath.sv
// wfgdd_datapath: process rows, configuration, dfs stack and marks, result register
// depends on wfgdd_pkg; driven by commands from wfgdd_ctrl
module wfgdd_datapath (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  wfgdd_pkg::dp_cmd_t                    cmd,
    output wfgdd_pkg::dp_status_t                 status,
    input  logic [wfgdd_pkg::PROC_W-1:0]          row_idx,
    input  logic [wfgdd_pkg::RES_NUM-1:0]         row_held,
    input  logic [wfgdd_pkg::RES_NUM-1:0]         row_req,
    input  logic                                  cfg_wr,
    input  logic                                  cfg_idx,
    input  logic [wfgdd_pkg::CNT_W-1:0]           cfg_val,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic                                  out_deadlock,
    output logic [wfgdd_pkg::PROC_W-1:0]          out_id,
    output logic                                  out_last
);

    logic [wfgdd_pkg::CNT_W-1:0]   proc_count_reg;
    logic [wfgdd_pkg::CNT_W-1:0]   res_count_reg;
    logic [wfgdd_pkg::RES_NUM-1:0] held_rows_reg    [wfgdd_pkg::PROC_NUM];
    logic [wfgdd_pkg::RES_NUM-1:0] request_rows_reg [wfgdd_pkg::PROC_NUM];
    logic [wfgdd_pkg::PROC_NUM-1:0] visited_reg;
    logic [wfgdd_pkg::PROC_NUM-1:0] onstack_reg;
    logic [wfgdd_pkg::PROC_W-1:0]  stack_node_reg   [wfgdd_pkg::PROC_NUM];
    logic [wfgdd_pkg::CNT_W-1:0]   stack_next_reg   [wfgdd_pkg::PROC_NUM];
    logic [wfgdd_pkg::PROC_W-1:0]  depth_of_reg     [wfgdd_pkg::PROC_NUM];
    logic [wfgdd_pkg::CNT_W-1:0]   sp_reg;
    logic [wfgdd_pkg::CNT_W-1:0]   s_reg;
    logic [wfgdd_pkg::PROC_W-1:0]  ptr_reg;
    logic [wfgdd_pkg::PROC_W-1:0]  start_reg;
    logic                          out_valid_reg;
    logic                          out_deadlock_reg;
    logic [wfgdd_pkg::PROC_W-1:0]  out_id_reg;
    logic                          out_last_reg;

    logic [wfgdd_pkg::CNT_W-1:0]   n_eff;
    logic [wfgdd_pkg::CNT_W-1:0]   r_eff;
    logic [wfgdd_pkg::RES_NUM-1:0] res_mask;
    logic [wfgdd_pkg::CNT_W-1:0]   sp_dec;
    logic [wfgdd_pkg::PROC_W-1:0]  top_idx;
    logic [wfgdd_pkg::PROC_W-1:0]  rd_idx;
    logic [wfgdd_pkg::PROC_W-1:0]  u_node;
    logic [wfgdd_pkg::CNT_W-1:0]   v_next;
    logic [wfgdd_pkg::PROC_W-1:0]  v_idx;
    logic [wfgdd_pkg::PROC_W-1:0]  s_idx;
    logic [wfgdd_pkg::PROC_W-1:0]  sp_idx;
    logic                          out_free;

    // saturated counts and resource mask
    assign n_eff = (proc_count_reg > wfgdd_pkg::PROC_LIMIT) ? wfgdd_pkg::PROC_LIMIT
                                                             : proc_count_reg;
    assign r_eff = (res_count_reg > wfgdd_pkg::RES_LIMIT) ? wfgdd_pkg::RES_LIMIT
                                                           : res_count_reg;
    always_comb begin
        for (int k = 0; k < wfgdd_pkg::RES_NUM; k++) begin
            res_mask[k] = (wfgdd_pkg::CNT_W'(k) < r_eff);
        end
    end

    // one stack read port: top of stack while searching, emit pointer while emitting
    assign sp_dec  = sp_reg - 1'b1;
    assign top_idx = sp_dec[wfgdd_pkg::PROC_W-1:0];
    assign sp_idx  = sp_reg[wfgdd_pkg::PROC_W-1:0];
    assign s_idx   = s_reg[wfgdd_pkg::PROC_W-1:0];
    assign rd_idx  = cmd.emit_node ? ptr_reg : top_idx;
    assign u_node  = stack_node_reg[rd_idx];
    assign v_next  = stack_next_reg[rd_idx];
    assign v_idx   = v_next[wfgdd_pkg::PROC_W-1:0];

    assign out_free = !out_valid_reg || out_ready;

    always_comb begin
        status.start_done    = (s_reg >= n_eff);
        status.start_visited = visited_reg[s_idx];
        status.sp_zero       = (sp_reg == '0);
        status.v_done        = (v_next >= n_eff);
        // wait-for edge u -> v, worked out from the rows on the fly
        status.has_edge      = (u_node != v_idx) &&
                               (|(request_rows_reg[u_node] & held_rows_reg[v_idx] & res_mask));
        status.v_visited     = visited_reg[v_idx];
        status.v_onstack     = onstack_reg[v_idx];
        status.emit_end      = ({1'b0, ptr_reg} + 1'b1) == sp_reg;
        status.out_free      = out_free;
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            proc_count_reg <= wfgdd_pkg::PROC_LIMIT;
            res_count_reg  <= wfgdd_pkg::RES_LIMIT;
            visited_reg    <= '0;
            onstack_reg    <= '0;
            sp_reg         <= '0;
            s_reg          <= '0;
            out_valid_reg  <= 1'b0;
            for (int p = 0; p < wfgdd_pkg::PROC_NUM; p++) begin
                held_rows_reg[p]    <= '0;
                request_rows_reg[p] <= '0;
            end
        end else begin
            if (cfg_wr) begin
                if (cfg_idx == wfgdd_pkg::CFG_PROC_COUNT) begin
                    proc_count_reg <= cfg_val;
                end else begin
                    res_count_reg <= cfg_val;
                end
            end
            if (cmd.row_wr) begin
                held_rows_reg[row_idx]    <= row_held;
                request_rows_reg[row_idx] <= row_req;
            end
            if (cmd.search_init) begin
                visited_reg <= '0;
                onstack_reg <= '0;
                sp_reg      <= '0;
                s_reg       <= '0;
            end
            if (cmd.start_skip) begin
                s_reg <= s_reg + 1'b1;
            end
            if (cmd.start_push) begin
                visited_reg[s_idx] <= 1'b1;
                onstack_reg[s_idx] <= 1'b1;
                sp_reg             <= wfgdd_pkg::CNT_W'(1);
            end
            if (cmd.pop) begin
                onstack_reg[u_node] <= 1'b0;
                sp_reg              <= sp_dec;
            end
            if (cmd.push_child) begin
                visited_reg[v_idx] <= 1'b1;
                onstack_reg[v_idx] <= 1'b1;
                sp_reg             <= sp_reg + 1'b1;
            end
            if (cmd.emit_node || cmd.emit_close || cmd.emit_none) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // stack contents, cycle bookkeeping and result payload
    always_ff @(posedge aclk) begin
        if (cmd.start_push) begin
            stack_node_reg[0]   <= s_idx;
            stack_next_reg[0]   <= '0;
            depth_of_reg[s_idx] <= '0;
        end
        if (cmd.advance) begin
            stack_next_reg[top_idx] <= v_next + 1'b1;
        end
        if (cmd.push_child) begin
            stack_node_reg[sp_idx] <= v_idx;
            stack_next_reg[sp_idx] <= '0;
            depth_of_reg[v_idx]    <= sp_idx;
        end
        if (cmd.mark_found) begin
            ptr_reg   <= depth_of_reg[v_idx];
            start_reg <= v_idx;
        end
        if (cmd.emit_node) begin
            ptr_reg          <= ptr_reg + 1'b1;
            out_deadlock_reg <= 1'b1;
            out_id_reg       <= u_node;
            out_last_reg     <= 1'b0;
        end
        if (cmd.emit_close) begin
            out_deadlock_reg <= 1'b1;
            out_id_reg       <= start_reg;
            out_last_reg     <= 1'b1;
        end
        if (cmd.emit_none) begin
            out_deadlock_reg <= 1'b0;
            out_id_reg       <= '0;
            out_last_reg     <= 1'b1;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_deadlock = out_deadlock_reg;
    assign out_id       = out_id_reg;
    assign out_last     = out_last_reg;

endmodule

### rtl/core/wfgdd_ctrl.sv
// wfgdd_ctrl: state machine sequencing row loads, the depth-first search and cycle output
// depends on wfgdd_pkg; steers wfgdd_datapath through dp_cmd_t / dp_status_t
module wfgdd_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  in_cmd,
    output wfgdd_pkg::dp_cmd_t    cmd,
    input  wfgdd_pkg::dp_status_t status
);

    wfgdd_pkg::state_t state_reg;
    wfgdd_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= wfgdd_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            wfgdd_pkg::ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    if (in_cmd == wfgdd_pkg::CMD_DETECT) begin
                        cmd.search_init = 1'b1;
                        state_next      = wfgdd_pkg::ST_START;
                    end else begin
                        cmd.row_wr = 1'b1;
                    end
                end
            end
            wfgdd_pkg::ST_START: begin
                priority if (status.start_done) begin
                    state_next = wfgdd_pkg::ST_NONE;
                end else if (status.start_visited) begin
                    cmd.start_skip = 1'b1;
                end else begin
                    cmd.start_push = 1'b1;
                    state_next     = wfgdd_pkg::ST_STEP;
                end
            end
            wfgdd_pkg::ST_STEP: begin
                priority if (status.sp_zero) begin
                    cmd.start_skip = 1'b1;
                    state_next     = wfgdd_pkg::ST_START;
                end else if (status.v_done) begin
                    cmd.pop = 1'b1;
                end else begin
                    cmd.advance = 1'b1;
                    if (status.has_edge && !status.v_visited) begin
                        cmd.push_child = 1'b1;
                    end else if (status.has_edge && status.v_onstack) begin
                        cmd.mark_found = 1'b1;
                        state_next     = wfgdd_pkg::ST_EMIT;
                    end
                end
            end
            wfgdd_pkg::ST_EMIT: begin
                if (status.out_free) begin
                    cmd.emit_node = 1'b1;
                    if (status.emit_end) begin
                        state_next = wfgdd_pkg::ST_CLOSE;
                    end
                end
            end
            wfgdd_pkg::ST_CLOSE: begin
                if (status.out_free) begin
                    cmd.emit_close = 1'b1;
                    state_next     = wfgdd_pkg::ST_IDLE;
                end
            end
            wfgdd_pkg::ST_NONE: begin
                if (status.out_free) begin
                    cmd.emit_none = 1'b1;
                    state_next    = wfgdd_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = wfgdd_pkg::ST_IDLE;
            end
        endcase
    end

endmodule
